/* design/jti_pkg.sv */
// Package for the joint trajectory interpolator: payload structs, register and
// command codes, widths and the saturation helper. No dependencies.
package jti_pkg;

  localparam int JOINTS     = 6;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_W      = 40;
  localparam int DEN_W      = 24;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam int JIDX_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE_MIN      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE_MAX      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRIPPER_STEPS   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRIPPER_IN_MAX  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRIPPER_DEG_MIN = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRIPPER_DEG_MAX = 4'd7;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_GDIV   = 4'd2;
  localparam logic [3:0] OP_GSPAN  = 4'd3;
  localparam logic [3:0] OP_MPREP  = 4'd4;
  localparam logic [3:0] OP_DSTART = 4'd5;
  localparam logic [3:0] OP_GOAL   = 4'd6;
  localparam logic [3:0] OP_SPREP  = 4'd7;
  localparam logic [3:0] OP_STEP   = 4'd8;
  localparam logic [3:0] OP_MEND   = 4'd9;
  localparam logic [3:0] OP_TICK   = 4'd10;
  localparam logic [3:0] OP_OUT    = 4'd11;

  // Input item command codes.
  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic        command;
    logic [11:0] pulse_0;
    logic [11:0] pulse_1;
    logic [11:0] pulse_2;
    logic [11:0] pulse_3;
    logic [11:0] pulse_4;
    logic [11:0] pulse_5;
    logic [15:0] move_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] angle_0;
    logic signed [31:0] angle_1;
    logic signed [31:0] angle_2;
    logic signed [31:0] angle_3;
    logic signed [31:0] angle_4;
    logic signed [31:0] angle_5;
    logic               reached;
  } out_t;

  typedef struct packed {
    logic [3:0]        op;
    logic [JIDX_W-1:0] joint;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic is_tick;
  } stat_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* design/jti_div.sv */
// Shared restoring divider, one quotient bit per cycle, on unsigned magnitudes.
// Depends on jti_pkg for the operand widths.
module jti_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [jti_pkg::NUM_W-1:0]  num,
  input  logic [jti_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [jti_pkg::NUM_W-1:0]  quo
);

  logic                        busy;
  logic [jti_pkg::CNT_W-1:0]   cnt;
  logic [jti_pkg::DEN_W-1:0]   rem;
  logic [jti_pkg::DEN_W:0]     trial;
  logic                        fits;

  // Shift the next dividend bit into the partial remainder and compare.
  assign trial = {rem, quo[jti_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == jti_pkg::CNT_W'(jti_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      if (fits) begin
        rem <= jti_pkg::DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[jti_pkg::DEN_W-1:0];
      end
      quo <= {quo[jti_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

/* design/jti_dp.sv */
// Datapath: configuration registers, joint state, operand preparation, the
// shared divider and the result register. Depends on jti_pkg and jti_div.
module jti_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  jti_pkg::cmd_t                  cmd,
  output jti_pkg::stat_t                 stat,
  input  jti_pkg::in_t                   item,
  input  logic                           cfg_write,
  input  logic [jti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jti_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output jti_pkg::out_t                  result
);

  // Configuration registers.
  logic [11:0]       pulse_min, pulse_max, gripper_steps, gripper_in_max;
  logic signed [8:0] degree_min, degree_max, gripper_deg_min, gripper_deg_max;

  // Joint state.
  logic signed [31:0] angle [jti_pkg::JOINTS];
  logic signed [31:0] step  [jti_pkg::JOINTS];
  logic signed [31:0] goal  [jti_pkg::JOINTS];
  logic [15:0]        ticks_done;
  logic [15:0]        duration;
  logic               arrived;

  // Captured item and move scratch registers.
  jti_pkg::in_t              item_reg;
  logic [23:0]               gspan;
  logic [jti_pkg::NUM_W-1:0] num_mag;
  logic [jti_pkg::DEN_W-1:0] den_mag;
  logic                      num_neg, den_neg, zero_den;
  logic signed [8:0]         lo_reg;

  // Divider interface.
  logic                      div_done;
  logic [jti_pkg::NUM_W-1:0] quo;

  // Combinational helpers.
  logic [11:0]        pulse_sel;
  logic [15:0]        dur_eff;
  logic signed [12:0] map_x;
  logic signed [9:0]  map_d;
  logic signed [8:0]  map_lo;
  logic signed [24:0] map_span;
  logic signed [22:0] prod;
  logic [22:0]        prod_mag;
  logic [23:0]        span_mag;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [11:0]        gquo;
  logic signed [40:0] qs;
  logic signed [41:0] goal_sum;
  logic signed [31:0] lo_q;
  logic               differs;
  logic               last_joint;

  jti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == jti_pkg::OP_DSTART),
    .num   (num_mag),
    .den   (den_mag),
    .done  (div_done),
    .quo   (quo)
  );

  assign stat.div_done = div_done;
  assign stat.out_free = !result_valid || !result_stall;
  assign stat.is_tick  = item_reg.command == jti_pkg::CMD_TICK;

  assign last_joint = cmd.joint == jti_pkg::JIDX_W'(jti_pkg::JOINTS - 1);
  assign dur_eff    = (item_reg.move_time == 16'd0) ? 16'd1 : item_reg.move_time;

  // Target pulse of the selected joint.
  always_comb begin
    case (cmd.joint)
      3'd0:    pulse_sel = item_reg.pulse_0;
      3'd1:    pulse_sel = item_reg.pulse_1;
      3'd2:    pulse_sel = item_reg.pulse_2;
      3'd3:    pulse_sel = item_reg.pulse_3;
      3'd4:    pulse_sel = item_reg.pulse_4;
      default: pulse_sel = item_reg.pulse_5;
    endcase
  end

  // Linear map operands: the gripper uses its own span and degree range.
  always_comb begin
    if (last_joint) begin
      map_x    = $signed({1'b0, pulse_sel});
      map_d    = 10'(gripper_deg_max) - 10'(gripper_deg_min);
      map_lo   = gripper_deg_min;
      map_span = $signed({1'b0, gspan});
    end else begin
      map_x    = $signed({1'b0, pulse_sel}) - $signed({1'b0, pulse_min});
      map_d    = 10'(degree_max) - 10'(degree_min);
      map_lo   = degree_min;
      map_span = 25'($signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min}));
    end
    prod     = 23'(map_x) * 23'(map_d);
    prod_mag = prod[22] ? 23'(-prod) : prod;
    span_mag = map_span[24] ? 24'(-map_span) : map_span[23:0];
  end

  // Step operands and divider result handling.
  always_comb begin
    diff     = 33'(goal[cmd.joint]) - 33'(angle[cmd.joint]);
    diff_mag = diff[32] ? 33'(-diff) : diff;
    gquo     = zero_den ? 12'd0 : quo[11:0];
    qs       = (num_neg ^ den_neg) ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    lo_q     = {{7{lo_reg[8]}}, lo_reg, 16'b0};
    goal_sum = 42'(qs) + 42'(lo_q);
  end

  // A tick moves only while some joint is away from its goal.
  always_comb begin
    differs = 1'b0;
    for (int i = 0; i < jti_pkg::JOINTS; i++) begin
      if (angle[i] != goal[i]) begin
        differs = 1'b1;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min       <= 12'd500;
      pulse_max       <= 12'd2500;
      degree_min      <= -9'sd90;
      degree_max      <= 9'sd90;
      gripper_steps   <= 12'd10;
      gripper_in_max  <= 12'd10;
      gripper_deg_min <= 9'sd0;
      gripper_deg_max <= 9'sd45;
    end else if (cfg_write) begin
      case (cfg_index)
        jti_pkg::REG_PULSE_MIN:       pulse_min       <= cfg_data;
        jti_pkg::REG_PULSE_MAX:       pulse_max       <= cfg_data;
        jti_pkg::REG_DEGREE_MIN:      degree_min      <= cfg_data[8:0];
        jti_pkg::REG_DEGREE_MAX:      degree_max      <= cfg_data[8:0];
        jti_pkg::REG_GRIPPER_STEPS:   gripper_steps   <= cfg_data;
        jti_pkg::REG_GRIPPER_IN_MAX:  gripper_in_max  <= cfg_data;
        jti_pkg::REG_GRIPPER_DEG_MIN: gripper_deg_min <= cfg_data[8:0];
        jti_pkg::REG_GRIPPER_DEG_MAX: gripper_deg_max <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Item capture, operand registers and gripper span.
  always_ff @(posedge clk) begin
    case (cmd.op)
      jti_pkg::OP_LOAD: begin
        item_reg <= item;
      end
      jti_pkg::OP_GDIV: begin
        num_mag  <= {28'b0, pulse_max};
        den_mag  <= {12'b0, gripper_steps};
        num_neg  <= 1'b0;
        den_neg  <= 1'b0;
        zero_den <= gripper_steps == 12'd0;
      end
      jti_pkg::OP_GSPAN: begin
        gspan <= 24'(gquo) * 24'(gripper_in_max);
      end
      jti_pkg::OP_MPREP: begin
        num_mag  <= {1'b0, prod_mag, 16'b0};
        den_mag  <= span_mag;
        num_neg  <= prod[22];
        den_neg  <= map_span[24];
        zero_den <= map_span == 25'sd0;
        lo_reg   <= map_lo;
      end
      jti_pkg::OP_SPREP: begin
        num_mag  <= {7'b0, diff_mag};
        den_mag  <= {8'b0, dur_eff};
        num_neg  <= diff[32];
        den_neg  <= 1'b0;
        zero_den <= 1'b0;
      end
      default: ;
    endcase
  end

  // Joint state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jti_pkg::JOINTS; i++) begin
        angle[i] <= '0;
        step[i]  <= '0;
        goal[i]  <= '0;
      end
      ticks_done <= '0;
      duration   <= '0;
      arrived    <= 1'b0;
    end else begin
      case (cmd.op)
        jti_pkg::OP_GOAL: begin
          goal[cmd.joint] <= zero_den ? lo_q : jti_pkg::sat32(goal_sum);
        end
        jti_pkg::OP_STEP: begin
          step[cmd.joint] <= jti_pkg::sat32(42'(qs));
        end
        jti_pkg::OP_MEND: begin
          duration   <= dur_eff;
          ticks_done <= '0;
          arrived    <= 1'b0;
        end
        jti_pkg::OP_TICK: begin
          if (!arrived && differs && (ticks_done < duration)) begin
            for (int i = 0; i < jti_pkg::JOINTS; i++) begin
              angle[i] <= jti_pkg::sat32(42'(angle[i]) + 42'(step[i]));
            end
            ticks_done <= ticks_done + 1'b1;
          end else begin
            arrived <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == jti_pkg::OP_OUT) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == jti_pkg::OP_OUT) begin
      result.angle_0 <= angle[0];
      result.angle_1 <= angle[1];
      result.angle_2 <= angle[2];
      result.angle_3 <= angle[3];
      result.angle_4 <= angle[4];
      result.angle_5 <= angle[5];
      result.reached <= arrived;
    end
  end

endmodule

/* design/jti_ctrl.sv */
// Controller state machine: sequences the gripper divisor division, goal and step
// divisions per joint, ticks and result hand-off. Depends on jti_pkg.
module jti_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  jti_pkg::stat_t stat,
  output jti_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_GDIV   = 4'd2;
  localparam logic [3:0] S_GSTART = 4'd3;
  localparam logic [3:0] S_GWAIT  = 4'd4;
  localparam logic [3:0] S_MPREP  = 4'd5;
  localparam logic [3:0] S_MSTART = 4'd6;
  localparam logic [3:0] S_MWAIT  = 4'd7;
  localparam logic [3:0] S_SPREP  = 4'd8;
  localparam logic [3:0] S_SSTART = 4'd9;
  localparam logic [3:0] S_SWAIT  = 4'd10;
  localparam logic [3:0] S_MEND   = 4'd11;
  localparam logic [3:0] S_TICK   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0]                 state, state_next;
  logic [jti_pkg::JIDX_W-1:0] joint, joint_next;
  logic                       last;

  assign item_stall = state != S_IDLE;
  assign last       = joint == jti_pkg::JIDX_W'(jti_pkg::JOINTS - 1);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    joint_next = joint;
    cmd.op     = jti_pkg::OP_NONE;
    cmd.joint  = joint;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op     = jti_pkg::OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        joint_next = '0;
        state_next = stat.is_tick ? S_TICK : S_GDIV;
      end
      S_GDIV: begin
        cmd.op     = jti_pkg::OP_GDIV;
        state_next = S_GSTART;
      end
      S_GSTART: begin
        cmd.op     = jti_pkg::OP_DSTART;
        state_next = S_GWAIT;
      end
      S_GWAIT: begin
        if (stat.div_done) begin
          cmd.op     = jti_pkg::OP_GSPAN;
          state_next = S_MPREP;
        end
      end
      S_MPREP: begin
        cmd.op     = jti_pkg::OP_MPREP;
        state_next = S_MSTART;
      end
      S_MSTART: begin
        cmd.op     = jti_pkg::OP_DSTART;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.div_done) begin
          cmd.op = jti_pkg::OP_GOAL;
          if (last) begin
            joint_next = '0;
            state_next = S_SPREP;
          end else begin
            joint_next = joint + 1'b1;
            state_next = S_MPREP;
          end
        end
      end
      S_SPREP: begin
        cmd.op     = jti_pkg::OP_SPREP;
        state_next = S_SSTART;
      end
      S_SSTART: begin
        cmd.op     = jti_pkg::OP_DSTART;
        state_next = S_SWAIT;
      end
      S_SWAIT: begin
        if (stat.div_done) begin
          cmd.op = jti_pkg::OP_STEP;
          if (last) begin
            state_next = S_MEND;
          end else begin
            joint_next = joint + 1'b1;
            state_next = S_SPREP;
          end
        end
      end
      S_MEND: begin
        cmd.op     = jti_pkg::OP_MEND;
        state_next = S_OUT;
      end
      S_TICK: begin
        cmd.op     = jti_pkg::OP_TICK;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op     = jti_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      joint <= '0;
    end else begin
      state <= state_next;
      joint <= joint_next;
    end
  end

endmodule

/* design/joint_trajectory_interpolator.sv */
// Top level of the joint trajectory interpolator: controller and datapath.
// Depends on jti_pkg, jti_ctrl, jti_dp (which holds jti_div).
//
//   channel  handshake               payload
//   item     item_valid/item_stall   item (move targets or tick)
//   result   result_valid/result_stall  result (six angles, reached)
//   cfg      cfg_valid/cfg_ready     cfg_index, cfg_data
//
// A tick transaction passes the decide, tick and output states after acceptance;
// the result is registered as the controller returns to idle to take the next item.
// A move runs 13 divisions (gripper divisor, six goals, six steps), each made
// of a prepare, a start and a wait for done on the shared one-bit-per-cycle
// divider, before the move ends and its result is handed off.
// One item is in flight at a time; a held result delays only the next item.
// Reset (rst, synchronous) restores register defaults and zeroes all joints.
module joint_trajectory_interpolator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  jti_pkg::in_t                   item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output jti_pkg::out_t                  result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jti_pkg::CFG_DATA_W-1:0] cfg_data
);

  jti_pkg::cmd_t  cmd;
  jti_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  jti_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  jti_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
